### rtl/assert_macros.svh
// Assertion macros shared by the TCP option parser RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCPOP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define TCPOP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tcpop_pkg.sv
// Shared types and constants for the TCP option parser.
// Used by tcpop_walk and tcp_option_parser; depends on nothing.
`default_nettype none

package tcpop_pkg;

	// Walk phases.
	localparam logic [1:0] PH_KIND = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// Option kinds of interest.
	localparam logic [7:0] KIND_EOL = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] KIND_WS  = 8'd3;
	localparam logic [7:0] KIND_TS  = 8'd8;

	// Body lengths of the captured options and limits.
	localparam logic [3:0] TS_BODY   = 4'd8;
	localparam logic [3:0] WS_BODY   = 4'd1;
	localparam logic [7:0] MIN_LEN   = 8'd2;
	localparam logic [3:0] MAX_SHIFT = 4'd14;
	localparam logic [3:0] POS_SAT   = 4'd15;

	// Stop codes reported with each result.
	localparam logic [1:0] STOP_AREA_END = 2'd0;
	localparam logic [1:0] STOP_EOL      = 2'd1;
	localparam logic [1:0] STOP_BAD_LEN  = 2'd2;
	localparam logic [1:0] STOP_PARTIAL  = 2'd3;

	// One input transfer.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} tcpop_item_t;

	// One result transfer.
	typedef struct packed {
		logic        ts_found;
		logic [31:0] ts_value;
		logic [31:0] ts_echo;
		logic        ws_found;
		logic [3:0]  window_shift;
		logic        shift_clamped;
		logic [1:0]  stop_code;
	} tcpop_result_t;

endpackage

`default_nettype wire

### rtl/tcpop_walk.sv
// Option list walker: holds the per-area parse state and folds in one item a cycle
// while step_en is high. Depends on tcpop_pkg.
`default_nettype none

module tcpop_walk (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step_en,
	input  wire tcpop_pkg::tcpop_item_t item,
	output logic                        emit,
	output tcpop_pkg::tcpop_result_t    result
);
	import tcpop_pkg::*;

	// Control state.
	logic [1:0]  phase_q;
	logic        halted_q;
	logic [1:0]  halt_code_q;
	logic        ts_seen_q;
	logic        ws_seen_q;

	// Payload state.
	logic [7:0]  cur_kind_q;
	logic [7:0]  body_left_q;
	logic [3:0]  body_pos_q;
	logic [63:0] ts_shift_q;
	logic [7:0]  ws_pending_q;
	logic [63:0] ts_hold_q;
	logic [3:0]  ws_hold_q;
	logic        ws_clamp_q;

	// Next values after the current byte.
	logic [1:0]  n_phase;
	logic        n_halted;
	logic [1:0]  n_halt_code;
	logic        n_ts_seen;
	logic        n_ws_seen;
	logic [7:0]  n_cur_kind;
	logic [7:0]  n_body_left;
	logic [3:0]  n_body_pos;
	logic [63:0] n_ts_shift;
	logic [7:0]  n_ws_pending;
	logic [63:0] n_ts_hold;
	logic [3:0]  n_ws_hold;
	logic        n_ws_clamp;

	// Apply one option byte to the walk.
	always_comb begin
		n_phase      = phase_q;
		n_halted     = halted_q;
		n_halt_code  = halt_code_q;
		n_ts_seen    = ts_seen_q;
		n_ws_seen    = ws_seen_q;
		n_cur_kind   = cur_kind_q;
		n_body_left  = body_left_q;
		n_body_pos   = body_pos_q;
		n_ts_shift   = ts_shift_q;
		n_ws_pending = ws_pending_q;
		n_ts_hold    = ts_hold_q;
		n_ws_hold    = ws_hold_q;
		n_ws_clamp   = ws_clamp_q;
		if (!item.empty && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (item.data < MIN_LEN) begin
						n_halted    = 1'b1;
						n_halt_code = STOP_BAD_LEN;
					end else begin
						n_body_left  = item.data - MIN_LEN;
						n_body_pos   = 4'd0;
						n_ts_shift   = 64'd0;
						n_ws_pending = 8'd0;
						// A zero-length body completes at once and captures nothing.
						n_phase = (n_body_left == 8'd0) ? PH_KIND : PH_BODY;
					end
				end
				PH_BODY: begin
					if (body_pos_q == 4'd0) begin
						n_ws_pending = item.data;
					end
					n_ts_shift  = {ts_shift_q[55:0], item.data};
					n_body_pos  = (body_pos_q < POS_SAT) ? body_pos_q + 4'd1 : body_pos_q;
					n_body_left = body_left_q - 8'd1;
					if (n_body_left == 8'd0) begin
						// Option complete: commit the first well-formed capture of each kind.
						if (cur_kind_q == KIND_TS && n_body_pos == TS_BODY && !ts_seen_q) begin
							n_ts_hold = n_ts_shift;
							n_ts_seen = 1'b1;
						end
						if (cur_kind_q == KIND_WS && n_body_pos == WS_BODY && !ws_seen_q) begin
							n_ws_clamp = (n_ws_pending > {4'd0, MAX_SHIFT});
							n_ws_hold  = n_ws_clamp ? MAX_SHIFT : n_ws_pending[3:0];
							n_ws_seen  = 1'b1;
						end
						n_phase = PH_KIND;
					end
				end
				default: begin
					if (item.data == KIND_EOL) begin
						n_halted    = 1'b1;
						n_halt_code = STOP_EOL;
					end else if (item.data != KIND_NOP) begin
						n_cur_kind = item.data;
						n_phase    = PH_LEN;
					end
				end
			endcase
		end
	end

	// The area ends on its last byte or on an empty mark.
	assign emit = item.last || item.empty;

	// Result as seen after the current byte.
	always_comb begin
		result.ts_found      = n_ts_seen;
		result.ts_value      = n_ts_seen ? n_ts_hold[63:32] : 32'd0;
		result.ts_echo       = n_ts_seen ? n_ts_hold[31:0] : 32'd0;
		result.ws_found      = n_ws_seen;
		result.window_shift  = n_ws_seen ? n_ws_hold : 4'd0;
		result.shift_clamped = n_ws_seen && n_ws_clamp;
		if (n_halted) begin
			result.stop_code = n_halt_code;
		end else if (n_phase == PH_LEN || n_phase == PH_BODY) begin
			result.stop_code = STOP_PARTIAL;
		end else begin
			result.stop_code = STOP_AREA_END;
		end
	end

	// Control state returns to its reset values when an area ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_KIND;
			halted_q    <= 1'b0;
			halt_code_q <= STOP_AREA_END;
			ts_seen_q   <= 1'b0;
			ws_seen_q   <= 1'b0;
		end else if (step_en) begin
			if (emit) begin
				phase_q     <= PH_KIND;
				halted_q    <= 1'b0;
				halt_code_q <= STOP_AREA_END;
				ts_seen_q   <= 1'b0;
				ws_seen_q   <= 1'b0;
			end else begin
				phase_q     <= n_phase;
				halted_q    <= n_halted;
				halt_code_q <= n_halt_code;
				ts_seen_q   <= n_ts_seen;
				ws_seen_q   <= n_ws_seen;
			end
		end
	end

	// Payload is always rewritten before it is used, or masked by its seen flag.
	always_ff @(posedge clk) begin
		if (step_en) begin
			cur_kind_q   <= n_cur_kind;
			body_left_q  <= n_body_left;
			body_pos_q   <= n_body_pos;
			ts_shift_q   <= n_ts_shift;
			ws_pending_q <= n_ws_pending;
			ts_hold_q    <= n_ts_hold;
			ws_hold_q    <= n_ws_hold;
			ws_clamp_q   <= n_ws_clamp;
		end
	end

endmodule

`default_nettype wire

### rtl/tcp_option_parser.sv
// TCP option parser top level: input register, option walker and result register.
// Depends on tcpop_pkg, tcpop_walk and assert_macros.svh.
//
// Usage:
// The option channel (option_valid, option_stall) carries one byte of a TCP option
// area per transfer, with last_byte on the final byte, or a single transfer with
// area_empty set for an area that holds no bytes. The result channel
// (result_valid, result_stall) gives one transfer per area: timestamp and window
// scale captures and a stop code.
// The byte that ends an area passes the input register; its result is then loaded
// into the result register.
// Throughput: one byte per cycle, back to back, across area boundaries, while
// option_stall is low; the walk state is a single register set updated by one short
// decision per byte. While the receiver stalls, the finished result holds and
// further bytes keep flowing until a second area end reaches the input register,
// which then raises option_stall until the waiting result is taken.
// Reset clears both registers' valid flags and returns the walk to the start
// of an area.
`default_nettype none

module tcp_option_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        option_valid,
	output logic             option_stall,
	input  wire logic [7:0]  option_byte,
	input  wire logic        last_byte,
	input  wire logic        area_empty,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             ts_found,
	output logic [31:0]      ts_value,
	output logic [31:0]      ts_echo,
	output logic             ws_found,
	output logic [3:0]       window_shift,
	output logic             shift_clamped,
	output logic [1:0]       stop_code
);
	import tcpop_pkg::*;
	`include "assert_macros.svh"

	logic          valid_s1;
	tcpop_item_t   item_s1;
	logic          emit_s1;
	logic          block_s1;
	logic          step_s1;
	logic          load_out;
	tcpop_result_t result_s1;
	logic          result_valid_q;
	tcpop_result_t result_q;

	// The input register waits only when it ends an area and the result is still held.
	assign block_s1     = valid_s1 && emit_s1 && result_valid_q && result_stall;
	assign option_stall = block_s1;
	assign step_s1      = valid_s1 && !block_s1;
	assign load_out     = step_s1 && emit_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!block_s1) begin
			valid_s1 <= option_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (option_valid && !block_s1) begin
			item_s1 <= '{data: option_byte, last: last_byte, empty: area_empty};
		end
	end

	// Walk state and per-byte decision.
	tcpop_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_s1),
		.item    (item_s1),
		.emit    (emit_s1),
		.result  (result_s1)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= load_out || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= result_s1;
		end
	end

	assign result_valid  = result_valid_q;
	assign ts_found      = result_q.ts_found;
	assign ts_value      = result_q.ts_value;
	assign ts_echo       = result_q.ts_echo;
	assign ws_found      = result_q.ws_found;
	assign window_shift  = result_q.window_shift;
	assign shift_clamped = result_q.shift_clamped;
	assign stop_code     = result_q.stop_code;

	// Checks on the pipeline and on result consistency.
	`TCPOP_ASSERT(a_stall_needs_item, !option_stall || (valid_s1 && emit_s1), "stall without a pending area end")
	`TCPOP_ASSERT_NEXT(a_load_shows, load_out, result_valid, "finished area did not reach the output")
	`TCPOP_ASSERT(a_shift_range, !result_valid || window_shift <= MAX_SHIFT, "window shift above limit")
	`TCPOP_ASSERT(a_ws_zero, !result_valid || ws_found || (window_shift == 4'd0 && !shift_clamped), "window scale fields set without a capture")
	`TCPOP_ASSERT(a_ts_zero, !result_valid || ts_found || (ts_value == 32'd0 && ts_echo == 32'd0), "timestamp fields set without a capture")

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for tcp_option_parser: option areas go in one byte per transfer,
// and each area result is checked against a cycle-free model of the option walk.
// Depends on tcpop_pkg and the tcp_option_parser RTL.
`timescale 1ns / 100ps

module tb;
	import tcpop_pkg::*;

	localparam int unsigned HOLD_OFF_CYCLES = 200;
	localparam int unsigned TAIL_CYCLES     = 8;

	logic        clk;
	logic        arst_n;
	logic        option_valid;
	logic        option_stall;
	logic [7:0]  option_byte;
	logic        last_byte;
	logic        area_empty;
	logic        result_valid;
	logic        result_stall;
	logic        ts_found;
	logic [31:0] ts_value;
	logic [31:0] ts_echo;
	logic        ws_found;
	logic [3:0]  window_shift;
	logic        shift_clamped;
	logic [1:0]  stop_code;

	tcp_option_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.option_valid (option_valid),
		.option_stall (option_stall),
		.option_byte  (option_byte),
		.last_byte    (last_byte),
		.area_empty   (area_empty),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ts_found     (ts_found),
		.ts_value     (ts_value),
		.ts_echo      (ts_echo),
		.ws_found     (ws_found),
		.window_shift (window_shift),
		.shift_clamped(shift_clamped),
		.stop_code    (stop_code)
	);

	// Stimulus and expected area results.
	tcpop_item_t   option_feed[$];
	tcpop_result_t area_results[$];
	logic [7:0]    area_buf[$];
	int unsigned   feed_count;
	int unsigned   error_count;

	// Idle control shared between the sequence and the two channel processes.
	int unsigned send_gap_max;
	int unsigned stall_max;
	int unsigned hold_request;

	// Per-edge handshake flags, set at the rising edge.
	logic byte_taken;
	logic result_taken;

	// Walk state of the option model.
	logic [1:0]  walk_phase;
	logic [7:0]  opt_kind;
	logic [7:0]  body_left;
	logic [3:0]  body_count;
	logic [63:0] body_shift;
	logic [7:0]  first_body;
	logic [63:0] ts_word;
	logic        ts_valid;
	logic [3:0]  ws_shift;
	logic        ws_valid;
	logic        ws_clamped;
	logic        walk_stopped;
	logic [1:0]  stop_reason;

	// Channel process variables.
	logic          send_hold;
	int unsigned   send_wait;
	tcpop_item_t   next_item;
	int unsigned   stall_wait;
	int unsigned   hold_left;
	int unsigned   hold_served;
	logic          stall_next;
	tcpop_result_t result_want;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Return the walk to the start of an area with nothing captured.
	task automatic clear_walk();
		walk_phase   = PH_KIND;
		opt_kind     = '0;
		body_left    = '0;
		body_count   = '0;
		body_shift   = '0;
		first_body   = '0;
		ts_word      = '0;
		ts_valid     = 1'b0;
		ws_shift     = '0;
		ws_valid     = 1'b0;
		ws_clamped   = 1'b0;
		walk_stopped = 1'b0;
		stop_reason  = STOP_AREA_END;
	endtask

	// An option just ended: commit the first well-sized timestamp and window scale.
	task automatic finish_option();
		if (opt_kind == KIND_TS && body_count == TS_BODY && !ts_valid) begin
			ts_word  = body_shift;
			ts_valid = 1'b1;
		end
		if (opt_kind == KIND_WS && body_count == WS_BODY && !ws_valid) begin
			ws_clamped = first_body > {4'd0, MAX_SHIFT};
			ws_shift   = ws_clamped ? MAX_SHIFT : first_body[3:0];
			ws_valid   = 1'b1;
		end
		walk_phase = PH_KIND;
	endtask

	// Advance the kind/length/body walk by one option byte.
	task automatic walk_byte(input logic [7:0] b);
		if (!walk_stopped) begin
			if (walk_phase == PH_LEN) begin
				if (b < MIN_LEN) begin
					walk_stopped = 1'b1;
					stop_reason  = STOP_BAD_LEN;
				end else begin
					body_left  = b - MIN_LEN;
					body_count = '0;
					body_shift = '0;
					first_body = '0;
					if (body_left == 0)
						finish_option();
					else
						walk_phase = PH_BODY;
				end
			end else if (walk_phase == PH_BODY) begin
				if (body_count == 0)
					first_body = b;
				body_shift = {body_shift[55:0], b};
				if (body_count != POS_SAT)
					body_count = body_count + 4'd1;
				body_left = body_left - 8'd1;
				if (body_left == 0)
					finish_option();
			end else begin
				if (b == KIND_EOL) begin
					walk_stopped = 1'b1;
					stop_reason  = STOP_EOL;
				end else if (b != KIND_NOP) begin
					opt_kind   = b;
					walk_phase = PH_LEN;
				end
			end
		end
	endtask

	// Apply one accepted transfer; an area end queues the expected result.
	task automatic predict_item(input logic [7:0] b, input logic lst, input logic emp);
		tcpop_result_t r;
		if (!emp)
			walk_byte(b);
		if (emp || lst) begin
			r.ts_found      = ts_valid;
			r.ts_value      = ts_valid ? ts_word[63:32] : 32'd0;
			r.ts_echo       = ts_valid ? ts_word[31:0] : 32'd0;
			r.ws_found      = ws_valid;
			r.window_shift  = ws_valid ? ws_shift : 4'd0;
			r.shift_clamped = ws_valid && ws_clamped;
			if (walk_stopped)
				r.stop_code = stop_reason;
			else if (walk_phase == PH_LEN || walk_phase == PH_BODY)
				r.stop_code = STOP_PARTIAL;
			else
				r.stop_code = STOP_AREA_END;
			area_results.push_back(r);
			clear_walk();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic put(input logic [7:0] b);
		area_buf.push_back(b);
	endtask

	// Move the built area into the feed; an empty area becomes a single empty
	// transfer, and a cut area ends on an empty transfer instead of a last byte.
	task automatic close_area(input logic cut_by_empty);
		tcpop_item_t it;
		int n;
		n = area_buf.size();
		for (int i = 0; i < n; i++) begin
			it.data  = area_buf[i];
			it.last  = (i == n - 1) && !cut_by_empty;
			it.empty = 1'b0;
			option_feed.push_back(it);
			feed_count++;
		end
		if (n == 0 || cut_by_empty) begin
			it.data  = 8'($urandom_range(0, 255));
			it.last  = 1'($urandom_range(0, 1));
			it.empty = 1'b1;
			option_feed.push_back(it);
			feed_count++;
		end
		area_buf.delete();
	endtask

	// One complete option, well formed or of a wrong length.
	task automatic random_option();
		int sel;
		int len;
		logic [7:0] k;
		sel = $urandom_range(0, 9);
		if (sel <= 1) begin
			put(KIND_NOP);
		end else if (sel <= 3) begin
			put(KIND_TS);
			put(8'd10);
			repeat (8) put(8'($urandom_range(0, 255)));
		end else if (sel <= 5) begin
			put(KIND_WS);
			put(8'd3);
			if ($urandom_range(0, 1))
				put(8'($urandom_range(0, 14)));
			else
				put(8'($urandom_range(15, 255)));
		end else if (sel <= 7) begin
			k = 8'($urandom_range(2, 255));
			if (k == KIND_WS || k == KIND_TS)
				k = k + 8'd1;
			len = $urandom_range(2, 8);
			put(k);
			put(8'(len));
			repeat (len - 2) put(8'($urandom_range(0, 255)));
		end else begin
			k   = (sel == 8) ? KIND_TS : KIND_WS;
			len = $urandom_range(2, 12);
			if (k == KIND_TS && len == 10)
				len = 11;
			if (k == KIND_WS && len == 3)
				len = 4;
			put(k);
			put(8'(len));
			repeat (len - 2) put(8'($urandom_range(0, 255)));
		end
	endtask

	// How the area ends: plainly, on end-of-list, on a bad length or mid-option.
	task automatic random_ending();
		int sel;
		int n;
		sel = $urandom_range(0, 3);
		if (sel == 1) begin
			put(KIND_EOL);
			repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
		end else if (sel == 2) begin
			put(8'($urandom_range(2, 255)));
			put(8'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
		end else if (sel == 3) begin
			put($urandom_range(0, 1) ? KIND_TS : 8'($urandom_range(2, 255)));
			n = $urandom_range(0, 8);
			if (n > 0) begin
				put(8'd10);
				repeat (n - 1) put(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic random_area();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			close_area(1'b0);
		end else if (r < 25) begin
			repeat ($urandom_range(1, 16)) put(8'($urandom_range(0, 255)));
			close_area($urandom_range(0, 9) == 0);
		end else begin
			repeat ($urandom_range(0, 4)) random_option();
			random_ending();
			close_area($urandom_range(0, 9) == 0);
		end
	endtask

	// Wait until every transfer is taken and every expected result has come.
	task automatic drain();
		while (option_feed.size() != 0 || option_valid || area_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned gap,
			input int unsigned stall, input logic hold_off);
		int unsigned start;
		send_gap_max = gap;
		stall_max    = stall;
		start        = feed_count;
		while (feed_count - start < count)
			random_area();
		if (hold_off) begin
			@(posedge clk);
			hold_request++;
		end
		drain();
	endtask

	// Sender: offers the next transfer after a random gap and holds it while stalled.
	always @(negedge clk) begin
		if (arst_n) begin
			send_hold = option_valid && !byte_taken;
			if (byte_taken)
				send_wait = $urandom_range(0, send_gap_max);
			if (!send_hold) begin
				if (send_wait != 0) begin
					send_wait--;
				end else if (option_feed.size() != 0) begin
					next_item = option_feed.pop_front();
					option_byte <= next_item.data;
					last_byte   <= next_item.last;
					area_empty  <= next_item.empty;
					send_hold = 1'b1;
				end
			end
			option_valid <= send_hold;
		end
	end

	// Receiver: random stall after each result, plus a long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request != hold_served) begin
				hold_served = hold_request;
				hold_left   = HOLD_OFF_CYCLES;
			end
			if (result_taken)
				stall_wait = $urandom_range(0, stall_max);
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_wait != 0) begin
				stall_wait--;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			result_stall <= stall_next;
		end
	end

	// Monitor: check each result transfer, then predict from each option transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_taken   <= 1'b0;
			result_taken <= 1'b0;
		end else begin
			byte_taken   <= option_valid && !option_stall;
			result_taken <= result_valid && !result_stall;
			if (result_valid && !result_stall) begin
				if (area_results.size() == 0) begin
					$display("%0t: result expected none actual stop_code %0d ts %h/%h",
						$time, stop_code, ts_value, ts_echo);
					error_count++;
				end else begin
					result_want = area_results.pop_front();
					check_field("ts_found", 32'(result_want.ts_found), 32'(ts_found));
					check_field("ts_value", result_want.ts_value, ts_value);
					check_field("ts_echo", result_want.ts_echo, ts_echo);
					check_field("ws_found", 32'(result_want.ws_found), 32'(ws_found));
					check_field("window_shift", 32'(result_want.window_shift),
						32'(window_shift));
					check_field("shift_clamped", 32'(result_want.shift_clamped),
						32'(shift_clamped));
					check_field("stop_code", 32'(result_want.stop_code), 32'(stop_code));
				end
			end
			if (option_valid && !option_stall)
				predict_item(option_byte, last_byte, area_empty);
		end
	end

	// Sequence: reset, directed areas, then random phases with different idling.
	initial begin
		arst_n       = 1'b0;
		option_valid = 1'b0;
		option_byte  = '0;
		last_byte    = 1'b0;
		area_empty   = 1'b0;
		result_stall = 1'b0;
		feed_count   = 0;
		error_count  = 0;
		send_gap_max = 4;
		stall_max    = 4;
		hold_request = 0;
		hold_served  = 0;
		hold_left    = 0;
		send_wait    = 0;
		stall_wait   = 0;
		clear_walk();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An area with no bytes.
		close_area(1'b0);
		// Timestamp with alternating bit patterns, then a window scale right at the clamp.
		put(KIND_TS);
		put(8'd10);
		put(8'hFF); put(8'h00); put(8'hAA); put(8'h55);
		put(8'h00); put(8'hFF); put(8'h55); put(8'hAA);
		put(KIND_WS);
		put(8'd3);
		put({4'd0, MAX_SHIFT});
		close_area(1'b0);
		// No-op, a window scale just past the clamp, then end-of-list.
		put(KIND_NOP);
		put(KIND_WS);
		put(8'd3);
		put(8'd15);
		put(KIND_EOL);
		close_area(1'b0);
		// Length below 2 on the last byte.
		put(8'd5);
		put(8'd1);
		close_area(1'b0);
		// A kind byte on the last byte.
		put(8'd9);
		close_area(1'b0);
		// A length of exactly 2 on the last byte completes the option.
		put(8'd9);
		put(MIN_LEN);
		close_area(1'b0);
		// A longer length on the last byte leaves the option partial.
		put(8'd4);
		put(8'd5);
		close_area(1'b0);
		// An empty mark while a window scale option is still open.
		put(KIND_WS);
		close_area(1'b1);
		drain();

		run_phase(200, 4, 4, 1'b0);
		run_phase(200, 0, 0, 1'b1);
		run_phase(200, 0, 4, 1'b0);
		run_phase(200, 4, 0, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && area_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
